// File: hdl/bounded_vector_store_core_macros.svh
// Assertion macros shared by the bounded vector store modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef BOUNDED_VECTOR_STORE_CORE_MACROS_SVH
`define BOUNDED_VECTOR_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BVS_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BVS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bvs_pkg.sv
// Shared types and constants for the bounded vector store.
// Used by the controller, the datapath and the top level; no dependencies.
package bvs_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OP_W         = 3;
  localparam int POS_W        = 9;
  localparam int LEN_W        = 9;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;

  localparam logic signed [WORD_W-1:0] READ_MISS_WORD = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_APPEND = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_ERASE  = 3'd4,
    OP_RESIZE = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RK_PLAIN,
    RK_HIT,
    RK_MISS
  } res_kind_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_READ_POS,
    DP_APPEND,
    DP_POP,
    DP_SETUP_UP,
    DP_STEP_UP,
    DP_PUT_POS,
    DP_SETUP_DN,
    DP_STEP_DN,
    DP_DEC,
    DP_SET_LEN,
    DP_SETUP_FILL,
    DP_FILL,
    DP_FILL_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t    op;
    logic      res_load;
    status_t   res_status;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_lt_cnt;
    logic pos_gt_cnt;
    logic cnt_full;
    logic cnt_zero;
    logic nlen_gt_cap;
    logic nlen_gt_cnt;
    logic mv_busy;
    logic fill_last;
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_UP,
    S_DN,
    S_FILL
  } state_t;

endpackage

// File: hdl/bvs_ctrl.sv
// Controller state machine for the bounded vector store.
// Depends on bvs_pkg and the shared assertion macro header.
`include "bounded_vector_store_core_macros.svh"

module bvs_ctrl import bvs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  // A result may be written when the output register is empty or being drained.
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
          unique case (stat.op)
            OP_READ: begin
              if (stat.pos_lt_cnt) state_next = S_RDWAIT;
            end
            OP_INSERT: begin
              if (!stat.pos_gt_cnt && !stat.cnt_full) state_next = S_UP;
            end
            OP_ERASE: begin
              if (stat.pos_lt_cnt) state_next = S_DN;
            end
            OP_RESIZE: begin
              if (!stat.nlen_gt_cap && stat.nlen_gt_cnt) state_next = S_FILL;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RDWAIT: begin
        if (slot_free) state_next = S_IDLE;
      end
      S_UP, S_DN: begin
        if (!stat.mv_busy && slot_free) state_next = S_IDLE;
      end
      S_FILL: begin
        if (stat.fill_last && slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '{op: DP_NONE, res_load: 1'b0, res_status: ST_DONE, res_kind: RK_PLAIN};
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_EXEC: begin
        if (slot_free) begin
          unique case (stat.op)
            OP_READ: begin
              if (stat.pos_lt_cnt) begin
                cmd.op = DP_READ_POS;
              end else begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_IGNORED;
                cmd.res_kind   = RK_MISS;
              end
            end
            OP_APPEND: begin
              cmd.res_load = 1'b1;
              if (stat.cnt_full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.op = DP_APPEND;
              end
            end
            OP_POP: begin
              cmd.res_load = 1'b1;
              if (stat.cnt_zero) begin
                cmd.res_status = ST_IGNORED;
              end else begin
                cmd.op = DP_POP;
              end
            end
            OP_INSERT: begin
              // The range check wins over the full check.
              if (stat.pos_gt_cnt) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_IGNORED;
              end else if (stat.cnt_full) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_FULL;
              end else begin
                cmd.op = DP_SETUP_UP;
              end
            end
            OP_ERASE: begin
              if (stat.pos_lt_cnt) begin
                cmd.op = DP_SETUP_DN;
              end else begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_IGNORED;
              end
            end
            OP_RESIZE: begin
              if (stat.nlen_gt_cap) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_IGNORED;
              end else if (stat.nlen_gt_cnt) begin
                cmd.op = DP_SETUP_FILL;
              end else begin
                cmd.op       = DP_SET_LEN;
                cmd.res_load = 1'b1;
              end
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_IGNORED;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_HIT;
        end
      end
      S_UP: begin
        if (stat.mv_busy) begin
          cmd.op = DP_STEP_UP;
        end else if (slot_free) begin
          cmd.op       = DP_PUT_POS;
          cmd.res_load = 1'b1;
        end
      end
      S_DN: begin
        if (stat.mv_busy) begin
          cmd.op = DP_STEP_DN;
        end else if (slot_free) begin
          cmd.op       = DP_DEC;
          cmd.res_load = 1'b1;
        end
      end
      S_FILL: begin
        if (!stat.fill_last) begin
          cmd.op = DP_FILL;
        end else if (slot_free) begin
          cmd.op       = DP_FILL_END;
          cmd.res_load = 1'b1;
        end
      end
      default: cmd.op = DP_NONE;
    endcase
  end

  `BVS_ASSERT_NOW(a_load_into_free_slot, clk, rst, cmd.res_load, !out_valid || out_ready, "result written over a waiting beat")
  `BVS_ASSERT_NEXT(a_accept_starts_exec, clk, rst, in_valid && in_ready, state == S_EXEC, "accepted beat did not start execution")
  `BVS_ASSERT_NEXT(a_valid_only_from_load, clk, rst, !out_valid && !cmd.res_load, !out_valid, "output valid rose without a result")

endmodule

// File: hdl/bvs_dpath.sv
// Datapath for the bounded vector store: word memory, count, move pointers
// and result registers. Depends on bvs_pkg and the assertion macro header.
`include "bounded_vector_store_core_macros.svh"

module bvs_dpath import bvs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [OP_W-1:0]          operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  input  logic [LEN_W-1:0]         new_length,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic [LEN_W-1:0]         length,
  output logic                     is_empty,
  output logic signed [WORD_W-1:0] read_value,
  output logic                     read_valid,
  output logic [STATUS_W-1:0]      status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];

  op_t                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [WORD_W-1:0]  val_q;
  logic [LEN_W-1:0]   nlen_q;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   ptr;
  logic [CNT_W-1:0]   ptr_p1;
  logic [CNT_W-1:0]   ptr_m1;
  logic [AW-1:0]      wr_ptr;
  logic               rd_more;
  logic               wr_pend;
  logic [WORD_W-1:0]  rdata;

  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   pos_p1;
  logic [CMP_W-1:0]   cnt_x;
  logic [CMP_W-1:0]   nlen_x;
  logic [CMP_W-1:0]   ptr_x;
  logic [CMP_W-1:0]   ptr_p1_x;
  logic [CMP_W-1:0]   cnt_next_x;
  logic [CMP_W-1:0]   wr_ptr_x;
  logic [CMP_W-1:0]   cap_x;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [WORD_W-1:0]  wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  assign pos_x      = CMP_W'(pos_q);
  assign pos_p1     = pos_x + CMP_W'(1);
  assign cnt_x      = CMP_W'(count);
  assign nlen_x     = CMP_W'(nlen_q);
  assign ptr_x      = CMP_W'(ptr);
  assign ptr_p1     = ptr + CNT_W'(1);
  assign ptr_m1     = ptr - CNT_W'(1);
  assign ptr_p1_x   = CMP_W'(ptr_p1);
  assign cnt_next_x = CMP_W'(count_next);
  assign wr_ptr_x   = CMP_W'(wr_ptr);
  assign cap_x      = CMP_W'(CAPACITY);

  assign stat.op          = op_q;
  assign stat.pos_lt_cnt  = pos_x < cnt_x;
  assign stat.pos_gt_cnt  = pos_x > cnt_x;
  assign stat.cnt_full    = cnt_x == cap_x;
  assign stat.cnt_zero    = count == '0;
  assign stat.nlen_gt_cap = nlen_x > cap_x;
  assign stat.nlen_gt_cnt = nlen_x > cnt_x;
  assign stat.mv_busy     = rd_more || wr_pend;
  assign stat.fill_last   = ptr_p1_x == nlen_x;

  always_comb begin
    unique case (cmd.op)
      DP_APPEND, DP_PUT_POS: count_next = count + CNT_W'(1);
      DP_POP, DP_DEC:        count_next = count - CNT_W'(1);
      DP_SET_LEN, DP_FILL_END: count_next = nlen_x[CNT_W-1:0];
      default:               count_next = count;
    endcase
  end

  // Memory port selection: one write and one read per cycle.
  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = '0;
    re    = 1'b0;
    raddr = ptr[AW-1:0];
    unique case (cmd.op)
      DP_APPEND: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
        wdata = val_q;
      end
      DP_PUT_POS: begin
        we    = 1'b1;
        waddr = pos_x[AW-1:0];
        wdata = val_q;
      end
      DP_READ_POS: begin
        re    = 1'b1;
        raddr = pos_x[AW-1:0];
      end
      DP_STEP_UP, DP_STEP_DN: begin
        we    = wr_pend;
        waddr = wr_ptr;
        wdata = rdata;
        re    = rd_more;
      end
      DP_FILL, DP_FILL_END: begin
        we = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_more <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      count <= count_next;
      unique case (cmd.op)
        DP_SETUP_UP: begin
          rd_more <= stat.pos_lt_cnt;
          wr_pend <= 1'b0;
        end
        DP_SETUP_DN: begin
          rd_more <= pos_p1 != cnt_x;
          wr_pend <= 1'b0;
        end
        DP_STEP_UP: begin
          // The last word to move up sits at the insert position.
          if (rd_more) rd_more <= ptr_x != pos_x;
          wr_pend <= rd_more;
        end
        DP_STEP_DN: begin
          if (rd_more) rd_more <= ptr_p1_x != cnt_x;
          wr_pend <= rd_more;
        end
        default: begin
          rd_more <= rd_more;
        end
      endcase
    end
  end

  // Pointers, latched beat fields and result registers carry no reset.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        op_q   <= op_t'(operation);
        pos_q  <= position;
        val_q  <= value;
        nlen_q <= new_length;
      end
      DP_SETUP_UP:   ptr <= count - CNT_W'(1);
      DP_SETUP_DN:   ptr <= pos_p1[CNT_W-1:0];
      DP_SETUP_FILL: ptr <= count;
      DP_FILL:       ptr <= ptr_p1;
      DP_STEP_UP: begin
        if (rd_more) begin
          ptr    <= ptr_m1;
          wr_ptr <= ptr_p1[AW-1:0];
        end
      end
      DP_STEP_DN: begin
        if (rd_more) begin
          ptr    <= ptr_p1;
          wr_ptr <= ptr_m1[AW-1:0];
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase

    if (cmd.res_load) begin
      length     <= cnt_next_x[LEN_W-1:0];
      is_empty   <= count_next == '0;
      status     <= cmd.res_status;
      read_valid <= cmd.res_kind == RK_HIT;
      unique case (cmd.res_kind)
        RK_HIT:  read_value <= rdata;
        RK_MISS: read_value <= READ_MISS_WORD;
        default: read_value <= '0;
      endcase
    end
  end

  `BVS_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, cnt_x <= cap_x, "element count above capacity")
  `BVS_ASSERT_NOW(a_up_write_range, clk, rst, wr_pend && op_q == OP_INSERT, wr_ptr_x > pos_x && wr_ptr_x <= cnt_x, "insert shift wrote outside its range")
  `BVS_ASSERT_NOW(a_dn_write_range, clk, rst, wr_pend && op_q == OP_ERASE, wr_ptr_x >= pos_x && wr_ptr_x + CMP_W'(1) < cnt_x, "erase shift wrote outside its range")

endmodule

// File: hdl/bounded_vector_store_core.sv
// Bounded vector store: an ordered array of up to CAPACITY signed 32-bit
// words with a live count, built from bvs_ctrl and bvs_dpath over bvs_pkg.
// Each input beat carries one operation (read, append, pop, insert, erase,
// resize) and yields exactly one output beat, and the core works on one beat
// at a time. With the output free, append, pop, a shrinking or same-length
// resize and every refused or ignored operation finish in the execute state
// that follows the load, and a read that hits adds a read-wait state. The
// word memory has one read port and one write port and moves one word per
// cycle, so an insert or an erase steps through the words between the
// position and the end of the array; a growing resize clears one word per
// cycle from the old count up to new_length. The longest operations are an
// insert at the front of a nearly full array and an erase at the front of a
// full one. A new beat is taken in the cycle after a result is written to
// the output register, even if that result still waits; the core then holds
// that beat until the output register frees up.
module bounded_vector_store_core import bvs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  input  logic [LEN_W-1:0]         new_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LEN_W-1:0]         length,
  output logic                     is_empty,
  output logic signed [WORD_W-1:0] read_value,
  output logic                     read_valid,
  output logic [STATUS_W-1:0]      status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bvs_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .new_length (new_length),
    .cmd        (cmd),
    .stat       (stat),
    .length     (length),
    .is_empty   (is_empty),
    .read_value (read_value),
    .read_valid (read_valid),
    .status     (status)
  );

endmodule
